// ===== hdl/pss_pkg.sv =====
// ============================================================================
// pss_pkg: shared types and constants of the polyphonic sine synthesizer
// Item structs, register indexes, sequencer codes and the frequency ROM.
// ============================================================================
`default_nettype none

package pss_pkg;

    localparam int VOICES       = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int V_W          = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W        = $clog2(VOICES + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic CMD_NOTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_END    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_END     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_END   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_END   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_PER_HZ  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN   = 3'd6;

    localparam logic [15:0] SIN_A = 16'd51472;
    localparam logic [15:0] SIN_B = 16'd21024;
    localparam logic [15:0] SIN_C = 16'd2320;

    localparam logic [29:0] FREQ_F_TOP = 30'd733227254;

    localparam logic [29:0] TONE_ROM [12] = '{
        30'd548668578, 30'd581294109, 30'd615859655, 30'd652480576,
        30'd691279090, 30'd732384684, 30'd775934544, 30'd822074013,
        30'd870957077, 30'd922746880, 30'd977616265, 30'd1035748353
    };

    typedef struct packed {
        logic       command;
        logic [6:0] note_number;
        logic [6:0] velocity;
    } t_in_item;

    typedef struct packed {
        logic               is_sample;
        logic signed [23:0] sample_value;
        logic [6:0]         active_voices;
        logic               note_dropped;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_VOICE, ST_SINE, ST_MUL, ST_DIV, ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_ENV, OP_X2, OP_CX2, OP_XT, OP_MAG, OP_EG, OP_EGV, OP_TERM, OP_STEP
    } t_mul_op;

    typedef enum logic [1:0] {
        RG_ATTACK, RG_DECAY, RG_RELEASE
    } t_region;

    // Note frequency in Q16.16 hertz: top-octave tone shifted down by octave,
    // rounding half up.
    function automatic logic [29:0] f_freq(input logic [6:0] n);
        logic [3:0]  oct;
        logic [6:0]  semi;
        logic [3:0]  sh;
        logic [30:0] base;
        logic [30:0] rnd;
        oct = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (n >= 7'(12 * i)) begin
                oct = 4'(i);
            end
        end
        semi = 7'(n - 7'(12 * oct));
        base = (semi == 7'd5 && n <= 7'd113) ? {1'b0, FREQ_F_TOP}
                                              : {1'b0, TONE_ROM[semi[3:0]]};
        sh   = 4'd10 - oct;
        rnd  = base + (31'd1 << (sh - 4'd1));
        if (sh == 4'd0) begin
            return base[29:0];
        end
        return 30'(rnd >> sh);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/polyphonic_adsr_sine_synth.sv =====
// ============================================================================
// polyphonic_adsr_sine_synth: voice-slot sine synthesizer with ADSR envelope
// Bit-serial multiply and divide walk all voices on each sample tick.
// ============================================================================
//
// Usage. An item is taken on a rising edge with start high and busy low.
// A note-on item claims the lowest free voice slot; when all slots are in use
// the note is dropped and note_dropped is set in its result. A tick item frees
// expired voices, sums envelope * gain * velocity * sine over the live voices
// and advances their age and phase. Every item gives exactly one result,
// shown on o_out for one cycle with o_strobe high; the receiver cannot stall.
//
// Timing. A note-on item gives its result on the next cycle and busy stays
// low, so another item may follow at once. A tick item keeps busy high while
// the voices are walked and shows its result in the cycle in which busy falls
// again; the next item is taken only once busy is low. Each live voice runs
// the envelope (at most a product, then a restoring divider), a sine fold step
// and eight products through one shift-add multiplier, one bit a cycle.
//
// Reset. A synchronous low reset frees every voice and loads the register
// defaults. Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Indexes past the list are ignored.
`default_nettype none

module polyphonic_adsr_sine_synth (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  pss_pkg::t_in_item                 i_in,
    output logic                              o_strobe,
    output pss_pkg::t_out_item                o_out,
    input  wire                               i_cfg_we,
    input  wire  [pss_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire  [pss_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import pss_pkg::*;

    localparam int MA_W  = 51;
    localparam int MB_W  = 20;
    localparam int SUM_W = 34;
    localparam logic [31:0] SINE_MASK = ~((32'd1 << (32 - SINE_BITS)) - 32'd1);
    localparam logic signed [SUM_W-1:0] SAT_MAX = 34'sd8388607;
    localparam logic signed [SUM_W-1:0] SAT_MIN = -34'sd8388608;

    // Configuration registers.
    logic [15:0] r_attack, r_decay, r_sus_end, r_release, r_sus_lvl;
    logic [19:0] r_pph;
    logic [7:0]  r_gain;

    // Control state.
    t_state          r_state, n_state;
    logic [VOICES-1:0] r_live, n_live;
    logic [CNT_W-1:0]  r_count, n_count;
    logic            r_strobe, n_strobe;

    // Voice storage (written on claim and on each voice update).
    logic [6:0]  r_note  [VOICES];
    logic [6:0]  r_level [VOICES];
    logic [15:0] r_age   [VOICES];
    logic [31:0] r_phase [VOICES];

    // Datapath registers.
    logic [V_W-1:0]   r_v, n_v;
    t_mul_op          r_op, n_op;
    t_region          r_rg, n_rg;
    logic [MA_W-1:0]  r_ma, n_ma, r_acc, n_acc;
    logic [MB_W-1:0]  r_mb, n_mb;
    logic [31:0]      r_num, n_num, r_q, n_q;
    logic [15:0]      r_rem, n_rem, r_den, n_den;
    logic [4:0]       r_cnt, n_cnt;
    logic [15:0]      r_env, n_env, r_x, n_x, r_x2, n_x2, r_mag, n_mag;
    logic             r_neg, n_neg;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    t_out_item        r_out, n_out;

    // Voice array write controls.
    logic           claim_we, upd_we;
    logic [V_W-1:0] free_idx;
    logic           free_found;
    logic [31:0]    upd_phase;
    logic [15:0]    upd_age;

    // Shared decodes.
    logic [15:0] cur_age, lvl;
    logic        cur_live, v_skip, v_last, is_att, is_dec, is_sus;
    logic        accept;

    assign accept   = start && !busy;
    assign cur_age  = r_age[r_v];
    assign cur_live = r_live[r_v];
    assign lvl      = (r_sus_lvl > 16'd32768) ? 16'd32768 : r_sus_lvl;
    assign v_skip   = !cur_live || (cur_age > r_release) || (cur_age == 16'hFFFF);
    assign v_last   = (r_v == V_W'(VOICES - 1));
    assign is_att   = (cur_age <= r_attack);
    assign is_dec   = (cur_age <= r_decay);
    assign is_sus   = (cur_age <= r_sus_end);

    // Lowest free slot for a note-on.
    always_comb begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int v = VOICES - 1; v >= 0; v--) begin
            if (!r_live[v]) begin
                free_idx   = V_W'(v);
                free_found = 1'b1;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.command == CMD_TICK) begin
                    n_state = ST_VOICE;
                end
            end
            ST_VOICE: begin
                if (v_skip) begin
                    n_state = v_last ? ST_DONE : ST_VOICE;
                end else if (is_att) begin
                    n_state = (r_attack == 16'd0) ? ST_SINE : ST_DIV;
                end else if (is_dec) begin
                    n_state = ST_MUL;
                end else if (is_sus) begin
                    n_state = ST_SINE;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_SINE: n_state = ST_MUL;
            ST_MUL: begin
                if (r_mb == '0) begin
                    if (r_op == OP_ENV) begin
                        n_state = ST_DIV;
                    end else if (r_op == OP_STEP) begin
                        n_state = v_last ? ST_DONE : ST_VOICE;
                    end
                end
            end
            ST_DIV: begin
                if (r_cnt == 5'd31) begin
                    n_state = ST_SINE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        busy = (r_state != ST_IDLE);
    end

    // Datapath.
    always_comb begin
        logic [16:0]    rem_sh;
        logic           qbit;
        logic [31:0]    qfin;
        logic [31:0]    ph;
        logic [14:0]    f;
        logic [50:0]    rnd;
        logic [20:0]    term;
        logic [31:0]    u;
        n_live    = r_live;
        n_count   = r_count;
        n_strobe  = 1'b0;
        n_out     = r_out;
        n_v       = r_v;
        n_op      = r_op;
        n_rg      = r_rg;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_acc     = r_acc;
        n_num     = r_num;
        n_q       = r_q;
        n_rem     = r_rem;
        n_den     = r_den;
        n_cnt     = r_cnt;
        n_env     = r_env;
        n_x       = r_x;
        n_x2      = r_x2;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_sum     = r_sum;
        claim_we  = 1'b0;
        upd_we    = 1'b0;
        upd_phase = r_phase[r_v] + r_acc[47:16];
        upd_age   = (cur_age == 16'hFFFF) ? cur_age : cur_age + 16'd1;
        rem_sh    = {r_rem, r_num[31]};
        qbit      = (rem_sh >= {1'b0, r_den});
        qfin      = {r_q[30:0], qbit};
        ph        = r_phase[r_v];
        u         = ph & SINE_MASK;
        f         = u[29:15];
        rnd       = r_acc + (51'd1 << 29);
        term      = rnd[50:30];

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in.command == CMD_NOTE) begin
                        n_strobe = 1'b1;
                        n_out.is_sample    = 1'b0;
                        n_out.sample_value = '0;
                        n_out.note_dropped = !free_found;
                        if (free_found) begin
                            claim_we          = 1'b1;
                            n_live[free_idx]  = 1'b1;
                            n_count           = r_count + CNT_W'(1);
                            n_out.active_voices = 7'(r_count + CNT_W'(1));
                        end else begin
                            n_out.active_voices = 7'(r_count);
                        end
                    end else begin
                        n_v   = '0;
                        n_sum = '0;
                    end
                end
            end
            ST_VOICE: begin
                n_cnt = '0;
                n_rem = '0;
                n_q   = '0;
                n_acc = '0;
                if (v_skip) begin
                    if (cur_live) begin
                        n_live[r_v] = 1'b0;
                        n_count     = r_count - CNT_W'(1);
                    end
                    n_v = r_v + V_W'(1);
                end else if (is_att) begin
                    n_env = 16'd32768;
                    n_rg  = RG_ATTACK;
                    n_num = {1'b0, cur_age, 15'd0};
                    n_den = r_attack;
                end else if (is_dec) begin
                    n_rg  = RG_DECAY;
                    n_op  = OP_ENV;
                    n_ma  = MA_W'(16'd32768 - lvl);
                    n_mb  = MB_W'(cur_age - r_attack);
                    n_den = r_decay - r_attack;
                end else if (is_sus) begin
                    n_env = lvl;
                end else begin
                    n_rg  = RG_RELEASE;
                    n_op  = OP_ENV;
                    n_ma  = MA_W'(lvl);
                    n_mb  = MB_W'(cur_age - r_sus_end);
                    n_den = r_release - r_sus_end;
                end
            end
            ST_DIV: begin
                n_rem = qbit ? 16'(rem_sh - {1'b0, r_den}) : rem_sh[15:0];
                n_num = {r_num[30:0], 1'b0};
                n_q   = qfin;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    case (r_rg)
                        RG_ATTACK:  n_env = qfin[15:0];
                        RG_DECAY:   n_env = 16'd32768 - qfin[15:0];
                        RG_RELEASE: n_env = lvl - qfin[15:0];
                        default:    n_env = '0;
                    endcase
                end
            end
            ST_SINE: begin
                n_x   = ph[30] ? 16'(17'd32768 - {2'b0, f}) : {1'b0, f};
                n_neg = ph[31];
                n_op  = OP_X2;
                n_acc = '0;
                n_ma  = MA_W'(n_x);
                n_mb  = MB_W'(n_x);
            end
            ST_MUL: begin
                if (r_mb != '0) begin
                    // One multiplier bit per cycle.
                    if (r_mb[0]) begin
                        n_acc = r_acc + r_ma;
                    end
                    n_ma = {r_ma[MA_W-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end else begin
                    n_acc = '0;
                    case (r_op)
                        OP_ENV: begin
                            n_num = r_acc[31:0];
                        end
                        OP_X2: begin
                            n_x2 = r_acc[30:15];
                            n_op = OP_CX2;
                            n_ma = MA_W'(SIN_C);
                            n_mb = MB_W'(r_acc[30:15]);
                        end
                        OP_CX2: begin
                            n_op = OP_XT;
                            n_ma = MA_W'(r_x2);
                            n_mb = MB_W'(SIN_B - r_acc[30:15]);
                        end
                        OP_XT: begin
                            n_op = OP_MAG;
                            n_ma = MA_W'(r_x);
                            n_mb = MB_W'(SIN_A - r_acc[30:15]);
                        end
                        OP_MAG: begin
                            n_mag = r_acc[30:15];
                            n_op  = OP_EG;
                            n_ma  = MA_W'(r_env);
                            n_mb  = MB_W'(r_gain);
                        end
                        OP_EG: begin
                            n_op = OP_EGV;
                            n_ma = MA_W'(r_acc[23:0]);
                            n_mb = MB_W'(r_level[r_v]);
                        end
                        OP_EGV: begin
                            n_op = OP_TERM;
                            n_ma = MA_W'(r_acc[30:0]);
                            n_mb = MB_W'(r_mag);
                        end
                        OP_TERM: begin
                            n_sum = r_neg ? r_sum - SUM_W'(term) : r_sum + SUM_W'(term);
                            n_op  = OP_STEP;
                            n_ma  = MA_W'(f_freq(r_note[r_v]));
                            n_mb  = r_pph;
                        end
                        OP_STEP: begin
                            upd_we = 1'b1;
                            n_v    = r_v + V_W'(1);
                        end
                        default: n_op = OP_ENV;
                    endcase
                end
            end
            ST_DONE: begin
                n_strobe            = 1'b1;
                n_out.is_sample     = 1'b1;
                n_out.note_dropped  = 1'b0;
                n_out.active_voices = 7'(r_count);
                if (r_sum > SAT_MAX) begin
                    n_out.sample_value = 24'sh7FFFFF;
                end else if (r_sum < SAT_MIN) begin
                    n_out.sample_value = 24'sh800000;
                end else begin
                    n_out.sample_value = r_sum[23:0];
                end
            end
            default: ;
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_live    <= '0;
            r_count   <= '0;
            r_strobe  <= 1'b0;
            r_attack  <= 16'd2756;
            r_decay   <= 16'd4961;
            r_sus_end <= 16'd8820;
            r_release <= 16'd11025;
            r_sus_lvl <= 16'd26214;
            r_pph     <= 20'd97391;
            r_gain    <= 8'd200;
        end else begin
            r_state  <= n_state;
            r_live   <= n_live;
            r_count  <= n_count;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ATTACK_END:    r_attack  <= i_cfg_data[15:0];
                    REG_DECAY_END:     r_decay   <= i_cfg_data[15:0];
                    REG_SUSTAIN_END:   r_sus_end <= i_cfg_data[15:0];
                    REG_RELEASE_END:   r_release <= i_cfg_data[15:0];
                    REG_SUSTAIN_LEVEL: r_sus_lvl <= i_cfg_data[15:0];
                    REG_PHASE_PER_HZ:  r_pph     <= i_cfg_data;
                    REG_OUTPUT_GAIN:   r_gain    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_v   <= n_v;
        r_op  <= n_op;
        r_rg  <= n_rg;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_acc <= n_acc;
        r_num <= n_num;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
        r_cnt <= n_cnt;
        r_env <= n_env;
        r_x   <= n_x;
        r_x2  <= n_x2;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_sum <= n_sum;
        r_out <= n_out;
    end

    // Voice storage.
    always_ff @(posedge i_clk) begin
        if (claim_we) begin
            r_note[free_idx]  <= i_in.note_number;
            r_level[free_idx] <= i_in.velocity;
            r_age[free_idx]   <= '0;
            r_phase[free_idx] <= '0;
        end else if (upd_we) begin
            r_phase[r_v] <= upd_phase;
            r_age[r_v]   <= upd_age;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

    // A note-on result always follows its item on the next cycle.
    a_note_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command == CMD_NOTE) |=> o_strobe)
        else $error("note-on item gave no result on the next cycle");

    // A tick keeps the block busy while the voices are walked.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command == CMD_TICK) |=> (busy && !o_strobe))
        else $error("tick item did not start the voice walk");

    // The voice count never exceeds the slot count.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(VOICES))
        else $error("active voice count out of range");

    // The envelope divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_den != 16'd0))
        else $error("envelope division with zero divisor");

endmodule

`default_nettype wire

// ===== tb/sv/polyphonic_adsr_sine_synth_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// polyphonic_adsr_sine_synth_tb: self-checking bench for the sine synthesizer
// A queue-fed driver sends note-on and tick items across several register
// settings. A predictor computes each item's result, and a monitor checks every
// strobed result against the oldest expected one.
// ============================================================================

module polyphonic_adsr_sine_synth_tb;
    import pss_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int QUIET_CYCLES   = 8;

    // An index past the register list; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;

    // The driver's queue holds three kinds of entries. Besides items it carries
    // register writes and sync points. A sync point waits until every expected
    // result has arrived, and then switches the idle mode of the sender.
    typedef enum logic [1:0] {K_ITEM, K_CFG, K_SYNC} t_kind;

    typedef struct {
        t_kind                 kind;
        t_in_item              item;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        int                    mode;
    } t_action;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    t_in_item              i_in       = '0;
    logic                  o_strobe;
    t_out_item             o_out;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    polyphonic_adsr_sine_synth i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_strobe   (o_strobe),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: its own copy of the registers and of every voice slot.
    // ------------------------------------------------------------------------
    logic [15:0] m_attack_end, m_decay_end, m_sustain_end, m_release_end;
    logic [15:0] m_sustain_level;
    logic [19:0] m_phase_per_hz;
    logic [7:0]  m_gain;

    logic        slot_live  [VOICES];
    logic [6:0]  slot_note  [VOICES];
    logic [6:0]  slot_vel   [VOICES];
    logic [15:0] slot_age   [VOICES];
    logic [31:0] slot_phase [VOICES];

    t_action   pending_actions[$];
    t_out_item expected_results[$];
    int        error_count  = 0;
    int        idle_mode    = 2;
    int        quiet_cycles = 0;
    int        stall_cycles = 0;
    t_in_item  driven_item  = '0;

    // Register writes land in the predictor when the driver issues them. This is
    // safe because a write is only issued while the block is idle.
    task automatic shadow_register_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_ATTACK_END:    m_attack_end    = data[15:0];
            REG_DECAY_END:     m_decay_end     = data[15:0];
            REG_SUSTAIN_END:   m_sustain_end   = data[15:0];
            REG_RELEASE_END:   m_release_end   = data[15:0];
            REG_SUSTAIN_LEVEL: m_sustain_level = data[15:0];
            REG_PHASE_PER_HZ:  m_phase_per_hz  = data[19:0];
            REG_OUTPUT_GAIN:   m_gain          = data[7:0];
            default: ;
        endcase
    endtask

    // Note frequency in Q16.16 hertz. The top-octave tone is shifted down by
    // octave with rounding half up. F notes up to 113 use the retuned FREQ_F_TOP.
    function automatic longint unsigned note_hz_q16(input logic [6:0] note);
        int unsigned octave, semitone, shift;
        longint unsigned top;
        octave   = note / 12;
        semitone = note % 12;
        top = (semitone == 5 && note <= 113) ? longint'(FREQ_F_TOP)
                                             : longint'(TONE_ROM[semitone]);
        shift = 10 - octave;
        if (shift == 0) begin
            return top;
        end
        return (top + (64'd1 << (shift - 1))) >> shift;
    endfunction

    // ADSR level in Q1.15 at a given age. The regions are tested in order, so an
    // empty region is simply passed over.
    function automatic longint unsigned adsr_level(input longint unsigned age);
        longint unsigned lvl;
        lvl = (m_sustain_level > 16'd32768) ? 32768 : m_sustain_level;
        if (age <= m_attack_end) begin
            return (m_attack_end == 0) ? 32768 : (age * 32768) / m_attack_end;
        end
        if (age <= m_decay_end) begin
            return 32768 - ((32768 - lvl) * (age - m_attack_end))
                           / (m_decay_end - m_attack_end);
        end
        if (age <= m_sustain_end) begin
            return lvl;
        end
        if (age <= m_release_end) begin
            return lvl - (lvl * (age - m_sustain_end)) / (m_release_end - m_sustain_end);
        end
        return 0;
    endfunction

    // Magnitude of the polynomial sine in Q15. The phase is first quantized to the
    // table resolution and then folded to a quarter wave.
    function automatic longint unsigned sine_magnitude(input logic [31:0] phase,
                                                       output logic negative);
        longint unsigned idx, turn, frac, x, x2, inner, outer;
        logic [1:0] quadrant;
        idx      = (longint'(phase) * SINE_ENTRIES) >> 32;
        turn     = (idx << 32) / SINE_ENTRIES;
        quadrant = turn[31:30];
        frac     = (turn >> 15) & 64'h7FFF;
        x        = quadrant[0] ? 32768 - frac : frac;
        x2       = (x * x) >> 15;
        inner    = longint'(SIN_B) - ((longint'(SIN_C) * x2) >> 15);
        outer    = longint'(SIN_A) - ((x2 * inner) >> 15);
        negative = quadrant[1];
        return (x * outer) >> 15;
    endfunction

    function automatic logic [6:0] live_count();
        int n;
        n = 0;
        for (int v = 0; v < VOICES; v++) begin
            n += slot_live[v];
        end
        return 7'(n);
    endfunction

    // Works out the result of one accepted item and updates the voice slots.
    function automatic t_out_item synth_result(input t_in_item item);
        t_out_item       res;
        longint          mix;
        longint unsigned mag, term, step;
        logic            negative;
        res = '0;
        if (item.command == CMD_NOTE) begin
            res.note_dropped = 1'b1;
            for (int v = 0; v < VOICES; v++) begin
                if (!slot_live[v] && res.note_dropped) begin
                    slot_live[v]     = 1'b1;
                    slot_note[v]     = item.note_number;
                    slot_vel[v]      = item.velocity;
                    slot_age[v]      = '0;
                    slot_phase[v]    = '0;
                    res.note_dropped = 1'b0;
                end
            end
            res.active_voices = live_count();
            return res;
        end
        // A voice past its release end is freed first. A voice whose age counter
        // has saturated is freed as well.
        for (int v = 0; v < VOICES; v++) begin
            if (slot_live[v] && (slot_age[v] > m_release_end || slot_age[v] == 16'hFFFF)) begin
                slot_live[v] = 1'b0;
            end
        end
        mix = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (slot_live[v]) begin
                mag  = sine_magnitude(slot_phase[v], negative);
                term = adsr_level(slot_age[v]) * m_gain * slot_vel[v] * mag;
                term = (term + (64'd1 << 29)) >> 30;
                mix += negative ? -longint'(term) : longint'(term);
                step = (note_hz_q16(slot_note[v]) * m_phase_per_hz) >> 16;
                slot_phase[v] = 32'(slot_phase[v] + step);
                if (slot_age[v] != 16'hFFFF) begin
                    slot_age[v] = slot_age[v] + 16'd1;
                end
            end
        end
        if (mix > 8388607) begin
            mix = 8388607;
        end
        if (mix < -8388608) begin
            mix = -8388608;
        end
        res.is_sample     = 1'b1;
        res.sample_value  = 24'(mix);
        res.active_voices = live_count();
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver. An item counts as accepted at an edge where start is high and
    // busy is low. The next entry is only taken from the queue after that edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic      taken;
        logic      settled;
        logic      cfg_we;
        t_action   act;
        t_out_item predicted;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                predicted        = synth_result(driven_item);
                expected_results = {expected_results, predicted};
            end
            // The block counts as settled once no result is owed and it has
            // been quiet for a while.
            settled = (expected_results.size() == 0) && !busy && !start
                      && (quiet_cycles >= QUIET_CYCLES);
            cfg_we = 1'b0;
            if (taken || !start) begin
                if (pending_actions.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    act = pending_actions[0];
                    case (act.kind)
                        K_CFG: begin
                            start <= 1'b0;
                            if (settled) begin
                                cfg_we      = 1'b1;
                                i_cfg_idx  <= act.idx;
                                i_cfg_data <= act.data;
                                shadow_register_write(act.idx, act.data);
                                void'(pending_actions.pop_front());
                            end
                        end
                        K_SYNC: begin
                            start <= 1'b0;
                            if (settled) begin
                                idle_mode = act.mode;
                                void'(pending_actions.pop_front());
                            end
                        end
                        default: begin
                            if ((idle_mode == 0 && $urandom_range(99) < 23) ||
                                (idle_mode == 1 && $urandom_range(99) < 51)) begin
                                start <= 1'b0;
                            end else begin
                                start       <= 1'b1;
                                i_in        <= act.item;
                                driven_item  = act.item;
                                void'(pending_actions.pop_front());
                            end
                        end
                    endcase
                end
            end
            i_cfg_we <= cfg_we;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. A result is valid for exactly one cycle, so it is checked at the
    // edge that ends that cycle.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            quiet_cycles <= (o_strobe || busy) ? 0 : quiet_cycles + 1;
            if (o_strobe) begin
                if (expected_results.size() == 0) begin
                    $error("result with nothing expected: %p", o_out);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.is_sample !== want.is_sample) begin
                        $error("is_sample: expected %0d, got %0d",
                               want.is_sample, o_out.is_sample);
                        error_count++;
                    end
                    if (o_out.sample_value !== want.sample_value) begin
                        $error("sample_value: expected %0d, got %0d",
                               want.sample_value, o_out.sample_value);
                        error_count++;
                    end
                    if (o_out.active_voices !== want.active_voices) begin
                        $error("active_voices: expected %0d, got %0d",
                               want.active_voices, o_out.active_voices);
                        error_count++;
                    end
                    if (o_out.note_dropped !== want.note_dropped) begin
                        $error("note_dropped: expected %0d, got %0d",
                               want.note_dropped, o_out.note_dropped);
                        error_count++;
                    end
                end
            end
        end
    end

    // The watchdog counts cycles in which neither an item nor a result moves.
    // The limit leaves room for a tick with all sixteen voices live several
    // times over.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            stall_cycles <= ((start && !busy) || o_strobe) ? 0 : stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------------
    task automatic add_item(input logic cmd, input logic [6:0] note,
                            input logic [6:0] vel);
        t_action a;
        a.kind = K_ITEM;
        a.item = '{command: cmd, note_number: note, velocity: vel};
        pending_actions = {pending_actions, a};
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        t_action a;
        a.kind = K_CFG;
        a.idx  = idx;
        a.data = data;
        pending_actions = {pending_actions, a};
    endtask

    task automatic add_sync(input int mode);
        t_action a;
        a.kind = K_SYNC;
        a.mode = mode;
        pending_actions = {pending_actions, a};
    endtask

    // Writes all seven registers. The envelope points are given in order, so the
    // caller decides whether the regions come out sorted or not.
    task automatic load_settings(input int atk, input int dec, input int sus,
                                 input int rel, input int lvl, input int pph,
                                 input int gain);
        add_write(REG_ATTACK_END,    CFG_DATA_W'(atk));
        add_write(REG_DECAY_END,     CFG_DATA_W'(dec));
        add_write(REG_SUSTAIN_END,   CFG_DATA_W'(sus));
        add_write(REG_RELEASE_END,   CFG_DATA_W'(rel));
        add_write(REG_SUSTAIN_LEVEL, CFG_DATA_W'(lvl));
        add_write(REG_PHASE_PER_HZ,  CFG_DATA_W'(pph));
        add_write(REG_OUTPUT_GAIN,   CFG_DATA_W'(gain));
    endtask

    // Random traffic. Short envelopes keep most voices expiring quickly, so the
    // ticks stay cheap while note-ons still fill the slots now and then.
    task automatic add_random_items(input int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(99) < 35) begin
                add_item(CMD_NOTE, 7'($urandom_range(127)),
                         ($urandom_range(9) == 0) ? 7'd0 : 7'($urandom_range(127)));
            end else begin
                add_item(CMD_TICK, 7'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        int a, d, s, r;
        m_attack_end    = 16'd2756;
        m_decay_end     = 16'd4961;
        m_sustain_end   = 16'd8820;
        m_release_end   = 16'd11025;
        m_sustain_level = 16'd26214;
        m_phase_per_hz  = 20'd97391;
        m_gain          = 8'd200;
        for (int v = 0; v < VOICES; v++) begin
            slot_live[v]  = 1'b0;
            slot_note[v]  = '0;
            slot_vel[v]   = '0;
            slot_age[v]   = '0;
            slot_phase[v] = '0;
        end

        // Directed part, run with the reset register values. It covers the
        // extreme notes and velocities, F notes with and without the retuning,
        // a zero velocity, and more note-ons than slots so that notes are dropped.
        add_sync(0);
        add_item(CMD_NOTE, 7'd0,   7'd127);
        add_item(CMD_NOTE, 7'd127, 7'd0);
        add_item(CMD_NOTE, 7'd65,  7'd100);
        add_item(CMD_NOTE, 7'd113, 7'd1);
        add_item(CMD_NOTE, 7'd125, 7'd127);
        add_item(CMD_TICK, 7'd127, 7'd127);
        add_item(CMD_TICK, 7'd0,   7'd0);
        for (int k = 0; k < 12; k++) begin
            add_item(CMD_NOTE, 7'(60 + k), 7'(10 * k + 7));
        end
        add_item(CMD_TICK, 7'd0, 7'd0);
        add_item(CMD_NOTE, 7'd69, 7'd64);
        add_item(CMD_TICK, 7'd0, 7'd0);

        // A short release end frees all sixteen voices over the next two ticks. The
        // index past the list and the extra high data bits must be ignored.
        add_write(REG_RELEASE_END, 20'hF0002);
        add_write(REG_NONE, 20'hFFFFF);
        add_item(CMD_TICK, 7'd0, 7'd0);
        add_item(CMD_TICK, 7'd0, 7'd0);
        add_item(CMD_TICK, 7'd0, 7'd0);
        add_item(CMD_TICK, 7'd0, 7'd0);

        // Extremes: zero envelope points, an oversized sustain level that is
        // clamped, the largest phase step and full gain.
        load_settings(0, 0, 0, 0, 65535, 1048575, 255);
        add_sync(1);
        add_random_items(100);

        // Regions out of order, full sustain level, no phase advance, zero gain.
        load_settings(20, 10, 30, 40, 32768, 0, 0);
        add_sync(2);
        add_random_items(100);

        // The longest attack, with a release that still ends soon.
        load_settings(65535, 3, 5, 25, 1, 1, 1);
        add_sync(0);
        add_random_items(100);

        // Random settings with short envelopes, mostly in order. The sender's
        // idle mode rotates from one phase to the next.
        for (int p = 0; p < 6; p++) begin
            a = $urandom_range(12);
            d = a + $urandom_range(12);
            s = d + $urandom_range(12);
            r = s + $urandom_range(20);
            if ($urandom_range(3) == 0) begin
                d = $urandom_range(30);
            end
            load_settings(a, d, s, r, $urandom_range(32768),
                          $urandom_range(1048575, 1), $urandom_range(255));
            add_sync((p + 1) % 3);
            add_random_items(100);
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_actions.size() == 0);
        @(posedge i_clk);
        wait (expected_results.size() == 0 && !start);
        repeat (400) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/pss_pkg.sv
hdl/polyphonic_adsr_sine_synth.sv
tb/sv/polyphonic_adsr_sine_synth_tb.sv
